[design/range_class_tokenizer_top_defines.svh]
// Assertion macros for the range class tokenizer.
`ifndef RANGE_CLASS_TOKENIZER_TOP_DEFINES_SVH
`define RANGE_CLASS_TOKENIZER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define RCT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RCT_ASSERT_DEF(lbl, prop, msg) \
  `RCT_ASSERT(lbl, clk_i, rst_ni, prop, msg)
`else
`define RCT_ASSERT(lbl, clk, rst_n, prop, msg)
`define RCT_ASSERT_DEF(lbl, prop, msg)
`endif

`endif

[design/rct_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package rct_pkg;

  localparam int unsigned RANGE_PAIRS_MAX = 8;
  localparam int unsigned BOUNDS_W = 8 * RANGE_PAIRS_MAX;
  localparam int unsigned PAIRS_W = 4;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned IN_TDATA_W = 8;
  localparam int unsigned OUT_TDATA_W = 32;

  localparam logic [BOUNDS_W-1:0] DEFAULT_BOUNDS = 64'h0000_0B09_0D0A_0C20;
  localparam logic [PAIRS_W-1:0] DEFAULT_PAIRS = 4'd6;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAIRS_USED = 2'd2;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       no_char;
    logic       end_of_string;
    logic       is_delimiter;
  } rct_item_t;

endpackage
`default_nettype wire

[design/rct_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module rct_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rct_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rct_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [7:0]                    char_byte_i,
  input  logic                          no_char_i,
  input  logic                          end_of_string_i,
  output rct_pkg::rct_item_t            item_o
);
  import rct_pkg::*;

  logic [BOUNDS_W-1:0] low_q, low_d;
  logic [BOUNDS_W-1:0] high_q, high_d;
  logic [PAIRS_W-1:0]  pairs_q, pairs_d;
  logic [RANGE_PAIRS_MAX-1:0] hit;

  always_comb begin
    low_d   = low_q;
    high_d  = high_q;
    pairs_d = pairs_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_RANGE_LOW:  low_d = cfg_data_i[BOUNDS_W-1:0];
        REG_RANGE_HIGH: high_d = cfg_data_i[BOUNDS_W-1:0];
        REG_PAIRS_USED: pairs_d = cfg_data_i[PAIRS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q   <= DEFAULT_BOUNDS;
      high_q  <= DEFAULT_BOUNDS;
      pairs_q <= DEFAULT_PAIRS;
    end else begin
      low_q   <= low_d;
      high_q  <= high_d;
      pairs_q <= pairs_d;
    end
  end

  // pair k active while k < pairs used; counts above the maximum enable all
  always_comb begin
    for (int k = 0; k < RANGE_PAIRS_MAX; k++) begin
      hit[k] = (PAIRS_W'(k) < pairs_q)
            && (char_byte_i >= low_q[8*k +: 8])
            && (char_byte_i <= high_q[8*k +: 8]);
    end
  end

  always_comb begin
    item_o.char_byte     = char_byte_i;
    item_o.no_char       = no_char_i;
    item_o.end_of_string = end_of_string_i;
    item_o.is_delimiter  = |hit;
  end

endmodule
`default_nettype wire

[design/rct_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "range_class_tokenizer_top_defines.svh"
module rct_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  rct_pkg::rct_item_t push_item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output rct_pkg::rct_item_t pop_item_o
);
  import rct_pkg::*;

  rct_item_t  slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign full_o     = count_q[1];
  assign empty_o    = (count_q == 2'd0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_item_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    count_d  = count_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

  `RCT_ASSERT_DEF(a_count_bound, count_q != 2'd3, "queue count exceeds depth")
  `RCT_ASSERT_DEF(a_ptr_gap, (count_q == 2'd1) |-> (wr_ptr_q != rd_ptr_q), "pointer gap mismatch")

endmodule
`default_nettype wire

[design/rct_back.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "range_class_tokenizer_top_defines.svh"
module rct_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  rct_pkg::rct_item_t item_i,
  output logic               pop_o,
  output logic               m_valid_o,
  input  logic               m_ready_i,
  output logic [7:0]         byte_out_o,
  output logic               is_delimiter_o,
  output logic               token_start_o,
  output logic               token_closed_o,
  output logic [rct_pkg::COUNT_W-1:0] token_number_o,
  output logic               empty_result_o,
  output logic               string_done_o
);
  import rct_pkg::*;

  logic               inside_q, inside_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic               valid_q, valid_d;
  logic [7:0]         byte_q;
  logic [COUNT_W-1:0] number_q;
  logic               delim_q, start_q, closed_q, empty_q, done_q;
  logic               delim, start, closed, in_next;
  logic [COUNT_W-1:0] cnt_next;
  logic               pop_last;

  assign pop_o    = !empty_i && (!valid_q || m_ready_i);
  assign pop_last = pop_o && item_i.end_of_string;

  always_comb begin
    delim    = !item_i.no_char && item_i.is_delimiter;
    start    = !item_i.no_char && !item_i.is_delimiter && !inside_q;
    cnt_next = (start && count_q != COUNT_MAX) ? count_q + 1'b1 : count_q;
    in_next  = item_i.no_char ? inside_q : !item_i.is_delimiter;
    closed   = (delim && inside_q) || (item_i.end_of_string && in_next);
    inside_d = inside_q;
    count_d  = count_q;
    valid_d  = valid_q && !m_ready_i;
    if (pop_o) begin
      valid_d  = 1'b1;
      inside_d = item_i.end_of_string ? 1'b0 : in_next;
      count_d  = item_i.end_of_string ? '0 : cnt_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= 1'b0;
      count_q  <= '0;
      valid_q  <= 1'b0;
    end else begin
      inside_q <= inside_d;
      count_q  <= count_d;
      valid_q  <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      byte_q   <= item_i.no_char ? 8'd0 : item_i.char_byte;
      delim_q  <= delim;
      start_q  <= start;
      closed_q <= closed;
      number_q <= cnt_next;
      empty_q  <= item_i.end_of_string && (cnt_next == '0);
      done_q   <= item_i.end_of_string;
    end
  end

  assign byte_out_o     = byte_q;
  assign token_number_o = number_q;
  assign m_valid_o      = valid_q;
  assign is_delimiter_o = delim_q;
  assign token_start_o  = start_q;
  assign token_closed_o = closed_q;
  assign empty_result_o = empty_q;
  assign string_done_o  = done_q;

  `RCT_ASSERT_DEF(a_start_counts, valid_q && start_q |-> number_q != '0, "start with zero count")
  `RCT_ASSERT_DEF(a_string_reset, pop_last |=> !inside_q && count_q == '0, "state not cleared")
  `RCT_ASSERT_DEF(a_start_excl, valid_q |-> !(start_q && (delim_q || empty_q)), "start on delimiter")

endmodule
`default_nettype wire

[design/range_class_tokenizer_top.sv]
// Results pass through the queue and the output register to the master side.
// Throughput: one byte per cycle sustained while m_axis_tready is high; the front
// classifies in the accept cycle, a 2-entry queue decouples it from the back end.
// Reset: asynchronous, active low; clears token state, queue and output valid,
// and loads the whitespace range set (space, FF, LF, CR, TAB, VT) with 6 pairs.
`timescale 1ns / 1ps
`default_nettype none
module range_class_tokenizer_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rct_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rct_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [rct_pkg::IN_TDATA_W-1:0] s_axis_tdata,  // char_byte
  input  logic                           s_axis_tuser,  // no_char
  input  logic                           s_axis_tlast,  // end_of_string
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // byte_out[7:0], token_start[8], token_closed[9], token_number[25:10],
  // empty_result[26], zero[31:27]
  output logic [rct_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                           m_axis_tuser,  // is_delimiter
  output logic                           m_axis_tlast   // string_done
);
  import rct_pkg::*;

  rct_item_t          front_item, queue_item;
  logic               q_full, q_empty, q_pop;
  logic [7:0]         byte_out;
  logic               token_start, token_closed, empty_result;
  logic [COUNT_W-1:0] token_number;

  assign s_axis_tready = !q_full;

  rct_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .char_byte_i     (s_axis_tdata),
    .no_char_i       (s_axis_tuser),
    .end_of_string_i (s_axis_tlast),
    .item_o          (front_item)
  );

  rct_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s_axis_tvalid),
    .push_item_i (front_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_item_o  (queue_item)
  );

  rct_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (q_empty),
    .item_i         (queue_item),
    .pop_o          (q_pop),
    .m_valid_o      (m_axis_tvalid),
    .m_ready_i      (m_axis_tready),
    .byte_out_o     (byte_out),
    .is_delimiter_o (m_axis_tuser),
    .token_start_o  (token_start),
    .token_closed_o (token_closed),
    .token_number_o (token_number),
    .empty_result_o (empty_result),
    .string_done_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {5'd0, empty_result, token_number, token_closed, token_start, byte_out};

endmodule
`default_nettype wire

[bench/range_class_tokenizer_checker.sv]
`timescale 1ns / 1ps
module range_class_tokenizer_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rct_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rct_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            s_tvalid_i,
  input  logic                            s_tready_i,
  input  logic [rct_pkg::IN_TDATA_W-1:0]  s_tdata_i,
  input  logic                            s_tuser_i,
  input  logic                            s_tlast_i,
  input  logic                            m_tvalid_i,
  input  logic                            m_tready_i,
  input  logic [rct_pkg::OUT_TDATA_W-1:0] m_tdata_i,
  input  logic                            m_tuser_i,
  input  logic                            m_tlast_i,
  output int unsigned                     mismatch_count_o,
  output int unsigned                     reports_pending_o
);
  import rct_pkg::*;

  typedef struct packed {
    logic [4:0]         pad;
    logic               empty;
    logic [COUNT_W-1:0] number;
    logic               closed;
    logic               start;
    logic               delim;
    logic               done;
    logic [7:0]         byte_out;
  } token_report_t;

  logic [BOUNDS_W-1:0] range_lo_q;
  logic [BOUNDS_W-1:0] range_hi_q;
  logic [PAIRS_W-1:0]  pairs_q;
  logic                in_token_q;
  logic [COUNT_W-1:0]  tokens_q;
  token_report_t       token_reports_q[$];
  token_report_t       predicted;
  token_report_t       observed;
  token_report_t       oldest;
  int unsigned         mismatches = 0;
  int unsigned         pending = 0;

  assign mismatch_count_o = mismatches;
  assign reports_pending_o = pending;

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  function automatic logic in_delim_class(input logic [7:0] b);
    int unsigned used;
    logic        hit;
    used = (pairs_q > RANGE_PAIRS_MAX) ? RANGE_PAIRS_MAX : pairs_q;
    hit = 1'b0;
    for (int unsigned k = 0; k < used; k++)
      if (b >= range_lo_q[8*k +: 8] && b <= range_hi_q[8*k +: 8]) hit = 1'b1;
    return hit;
  endfunction

  task automatic tokenize(input logic [7:0] b, input logic no_char, input logic last,
                          output token_report_t r);
    r = '0;
    r.done = last;
    if (!no_char) begin
      r.byte_out = b;
      r.delim = in_delim_class(b);
      if (r.delim) begin
        r.closed = in_token_q;
        in_token_q = 1'b0;
      end else begin
        r.start = !in_token_q;
        if (r.start && tokens_q != COUNT_MAX) tokens_q++;
        in_token_q = 1'b1;
      end
    end
    if (last) begin
      if (in_token_q) r.closed = 1'b1;
      r.empty = (tokens_q == '0);
    end
    r.number = tokens_q;
    if (last) begin
      in_token_q = 1'b0;
      tokens_q = '0;
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      range_lo_q = DEFAULT_BOUNDS;
      range_hi_q = DEFAULT_BOUNDS;
      pairs_q = DEFAULT_PAIRS;
      in_token_q = 1'b0;
      tokens_q = '0;
      token_reports_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_RANGE_LOW:  range_lo_q = cfg_data_i[BOUNDS_W-1:0];
          REG_RANGE_HIGH: range_hi_q = cfg_data_i[BOUNDS_W-1:0];
          REG_PAIRS_USED: pairs_q = cfg_data_i[PAIRS_W-1:0];
          default: ;
        endcase
      end
      if (m_tvalid_i && m_tready_i) begin
        observed = '0;
        observed.byte_out = m_tdata_i[7:0];
        observed.start = m_tdata_i[8];
        observed.closed = m_tdata_i[9];
        observed.number = m_tdata_i[25:10];
        observed.empty = m_tdata_i[26];
        observed.pad = m_tdata_i[31:27];
        observed.delim = m_tuser_i;
        observed.done = m_tlast_i;
        if (token_reports_q.size() == 0) begin
          report_mismatch($sformatf("result %0h with nothing outstanding", m_tdata_i));
        end else begin
          oldest = token_reports_q.pop_front();
          check_field("byte_out", 32'(observed.byte_out), 32'(oldest.byte_out));
          check_field("is_delimiter", 32'(observed.delim), 32'(oldest.delim));
          check_field("token_start", 32'(observed.start), 32'(oldest.start));
          check_field("token_closed", 32'(observed.closed), 32'(oldest.closed));
          check_field("token_number", 32'(observed.number), 32'(oldest.number));
          check_field("empty_result", 32'(observed.empty), 32'(oldest.empty));
          check_field("string_done", 32'(observed.done), 32'(oldest.done));
          check_field("pad bits", 32'(observed.pad), 32'(oldest.pad));
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        tokenize(s_tdata_i, s_tuser_i, s_tlast_i, predicted);
        token_reports_q.push_back(predicted);
      end
    end
    pending = token_reports_q.size();
  end

endmodule

[bench/range_class_tokenizer_top_tb.sv]
`timescale 1ns / 1ps
module range_class_tokenizer_top_tb;
  import rct_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned ITEMS_PER_SETTING = 110;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tuser = 1'b0;
  logic                   s_axis_tlast = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   m_axis_tlast;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned cycles = 0;
  int unsigned src_idle = 8;
  int unsigned sink_idle = 68;

  logic [BOUNDS_W-1:0] bounds_lo = DEFAULT_BOUNDS;
  logic [BOUNDS_W-1:0] bounds_hi = DEFAULT_BOUNDS;
  logic [PAIRS_W-1:0]  pairs_used = DEFAULT_PAIRS;

  range_class_tokenizer_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  range_class_tokenizer_checker checker_i (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .s_tvalid_i        (s_axis_tvalid),
    .s_tready_i        (s_axis_tready),
    .s_tdata_i         (s_axis_tdata),
    .s_tuser_i         (s_axis_tuser),
    .s_tlast_i         (s_axis_tlast),
    .m_tvalid_i        (m_axis_tvalid),
    .m_tready_i        (m_axis_tready),
    .m_tdata_i         (m_axis_tdata),
    .m_tuser_i         (m_axis_tuser),
    .m_tlast_i         (m_axis_tlast),
    .mismatch_count_o  (mismatches),
    .reports_pending_o (pending)
  );

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_idle);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send(input logic [7:0] b, input logic no_char, input logic last);
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tuser <= no_char;
    s_axis_tlast <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // drop valid and let the pipeline empty before touching registers
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    case (idx)
      REG_RANGE_LOW:  bounds_lo = data[BOUNDS_W-1:0];
      REG_RANGE_HIGH: bounds_hi = data[BOUNDS_W-1:0];
      REG_PAIRS_USED: pairs_used = data[PAIRS_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [7:0] pick_byte();
    int unsigned used;
    int unsigned k;
    logic [7:0]  lo;
    logic [7:0]  hi;
    used = (pairs_used > RANGE_PAIRS_MAX) ? RANGE_PAIRS_MAX : pairs_used;
    if (used == 0 || $urandom_range(1) == 0) return 8'($urandom_range(255));
    k = $urandom_range(used - 1);
    lo = bounds_lo[8*k +: 8];
    hi = bounds_hi[8*k +: 8];
    if (lo > hi) return 8'($urandom_range(255));
    return 8'($urandom_range(hi, lo));
  endfunction

  task automatic run_strings(input int unsigned n);
    int unsigned sent;
    int unsigned len;
    logic        tail_mark;
    sent = 0;
    while (sent < n) begin
      len = ($urandom_range(9) == 0) ? 0 : $urandom_range(24, 1);
      tail_mark = (len == 0) || ($urandom_range(7) == 0);
      for (int unsigned i = 0; i < len; i++) begin
        send(pick_byte(), $urandom_range(15) == 0, (i == len - 1) && !tail_mark);
        sent++;
      end
      if (tail_mark) begin
        send(8'($urandom_range(255)), 1'b1, 1'b1);
        sent++;
      end
    end
  endtask

  task automatic apply_setting(input int unsigned n);
    logic [BOUNDS_W-1:0]   lo;
    logic [BOUNDS_W-1:0]   hi;
    logic [CFG_DATA_W-1:0] pairs_word;
    lo = {$urandom, $urandom};
    for (int k = 0; k < RANGE_PAIRS_MAX; k++)
      hi[8*k +: 8] = lo[8*k +: 8] + 8'($urandom_range(12));
    pairs_word = {$urandom, $urandom};
    pairs_word[PAIRS_W-1:0] = 4'($urandom_range(15));
    case (n)
      0: begin
        write_reg(REG_UNMAPPED, {$urandom, $urandom});
        return;
      end
      1: pairs_word[PAIRS_W-1:0] = 4'd0;
      2: begin
        lo[7:0] = 8'h00;
        hi[7:0] = 8'h2F;
        lo[15:8] = 8'hF0;
        hi[15:8] = 8'h10;
        pairs_word[PAIRS_W-1:0] = 4'd8;
      end
      3: pairs_word[PAIRS_W-1:0] = 4'd15;
      4: begin
        lo = '0;
        hi = '1;
        pairs_word[PAIRS_W-1:0] = 4'd1;
      end
      5: begin
        lo = '1;
        hi = '0;
        pairs_word[PAIRS_W-1:0] = 4'd8;
      end
      6: begin
        lo[7:0] = 8'hF0;
        hi[7:0] = 8'hFF;
        pairs_word[PAIRS_W-1:0] = 4'd4;
      end
      default: ;
    endcase
    write_reg(REG_RANGE_LOW, lo);
    write_reg(REG_RANGE_HIGH, hi);
    write_reg(REG_PAIRS_USED, pairs_word);
  endtask

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send(8'h41, 1'b0, 1'b0);
    send(8'hFF, 1'b0, 1'b0);
    send(8'h20, 1'b0, 1'b0);
    send(8'h09, 1'b0, 1'b0);
    send(8'h00, 1'b0, 1'b0);
    send(8'h5A, 1'b1, 1'b0);
    send(8'h0D, 1'b0, 1'b1);
    send(8'hFF, 1'b1, 1'b1);
    send(8'h0A, 1'b0, 1'b0);
    send(8'h0B, 1'b0, 1'b0);
    send(8'h0C, 1'b0, 1'b1);
    send(8'h7E, 1'b0, 1'b1);
    send(8'h21, 1'b0, 1'b0);
    send(8'h08, 1'b0, 1'b0);
    send(8'h0E, 1'b1, 1'b0);
    send(8'h20, 1'b0, 1'b0);
    send(8'h1F, 1'b0, 1'b0);
    send(8'hAA, 1'b1, 1'b1);

    for (int p = 0; p < 3; p++) begin
      src_idle = (p == 0) ? 8 : (p == 1) ? 68 : 0;
      sink_idle = (p == 0) ? 68 : (p == 1) ? 8 : 0;
      for (int s = 0; s < 4; s++) begin
        settle();
        apply_setting(4 * p + s);
        run_strings(ITEMS_PER_SETTING);
      end
    end

    settle();
    repeat (8) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
